### hw/rtl/bpa_pkg.sv
package bpa_pkg;

	localparam int PN_W = 44;
	localparam int ST_W = 3;
	localparam int RQ_W = 4;

	localparam logic [PN_W-1:0] BASE_RST = PN_W'(64'h8000_0000 >> 12);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [ST_W-1:0] STAT_OK        = 3'd0;
	localparam logic [ST_W-1:0] STAT_DBL_FREE  = 3'd1;
	localparam logic [ST_W-1:0] STAT_NO_MEM    = 3'd2;
	localparam logic [ST_W-1:0] STAT_TOO_LARGE = 3'd3;
	localparam logic [ST_W-1:0] STAT_RANGE     = 3'd4;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_A_RD,
		ST_A_S1,
		ST_A_S2,
		ST_A_FIN,
		ST_F_RD,
		ST_M_CHK,
		ST_M_BUD,
		ST_R_START,
		ST_R_WALK,
		ST_R_WB,
		ST_R_WT,
		ST_R_RD,
		ST_R_POP,
		ST_R_END,
		ST_M_PUSH,
		ST_DONE
	} state_t;

endpackage

### hw/rtl/bpa_ram.sv
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/buddy_page_allocator.sv
// Buddy page allocator over 2^MAX_ORDER pages; per-page link, order and held bit in one RAM.
// An allocate splits larger blocks down to the requested order; a free merges with free buddies
// level by level, walking the free list to unlink each merged block that is not at its list head.
// One word in flight; the next word is taken in the cycle after the result is loaded.
// After reset a clearing pass marks every page held at order 0; no word is accepted during
// it, configuration writes are always taken.
module buddy_page_allocator import bpa_pkg::*; #(
	parameter int MAX_ORDER = 13
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [PN_W-1:0] cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            opcode,
	input  logic [RQ_W-1:0] order,
	input  logic [PN_W-1:0] page_number,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [ST_W-1:0] status,
	output logic [PN_W-1:0] alloc_page
);

	localparam int IW = MAX_ORDER;
	localparam int OW = $clog2(MAX_ORDER + 1);
	localparam int PC = 1 << MAX_ORDER;
	localparam int HD = MAX_ORDER + 1;

	typedef struct packed {
		logic          nv;
		logic [IW-1:0] link;
		logic [OW-1:0] ord;
		logic          held;
	} word_t;

	state_t state_q, state_d;

	logic [PN_W-1:0] base_q;
	logic            op_q;
	logic [RQ_W-1:0] req_q;
	logic [PN_W-1:0] pn_q;
	logic [IW-1:0]   head_q [HD];
	logic [HD-1:0]   hv_q;
	logic [IW-1:0]   head_d [HD];
	logic [HD-1:0]   hv_d;
	logic [OW-1:0]   lvl_q, k_q;
	logic [IW-1:0]   p_q, b_q, lo_q, tgt_q, t_q, first_q, before_q;
	logic            rm2_q, found_q;
	word_t           bword_q, tword_q;
	logic [IW:0]     steps_q;
	logic [IW-1:0]   clr_q;
	logic [ST_W-1:0] rs_status_q, status_q;
	logic [PN_W-1:0] rs_page_q, page_q;
	logic            out_valid_q;

	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	word_t         ram_wdata, rword;

	logic [OW-1:0] hk;
	logic [IW-1:0] hsel_link;
	logic          hsel_v;
	logic          h0_we, h1_we, h0_v;
	logic [OW-1:0] h0_idx, h1_idx;
	logic [IW-1:0] h0_link, h1_link;

	logic            res_we;
	logic [ST_W-1:0] res_code;
	logic            out_load;

	logic [OW-1:0]   req_k, km1, kp1, scan_lvl;
	logic            req_ok, scan_hit;
	logic [PN_W-1:0] diff;
	logic            oor;
	logic [IW-1:0]   bud_m, bud_a, lo_c, hi_c;
	logic            walk_go;

	bpa_ram #(
		.WIDTH($bits(word_t)),
		.DEPTH(PC)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rword)
	);

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign alloc_page = page_q;

	assign req_k   = OW'(req_q);
	assign req_ok  = int'(req_q) <= MAX_ORDER;
	assign km1     = lvl_q - OW'(1);
	assign kp1     = k_q + OW'(1);
	assign diff    = pn_q - base_q;
	assign oor     = (pn_q < base_q) || ((diff >> IW) != '0);
	assign bud_m   = p_q ^ (IW'(1) << k_q);
	assign bud_a   = b_q ^ (IW'(1) << km1);
	assign lo_c    = (p_q < b_q) ? p_q : b_q;
	assign hi_c    = (p_q < b_q) ? b_q : p_q;
	assign walk_go = rword.nv && !steps_q[IW];

	assign hsel_link = head_q[hk];
	assign hsel_v    = hv_q[hk];

	always_comb begin
		scan_hit = 1'b0;
		scan_lvl = '0;
		for (int j = MAX_ORDER; j >= 0; j--) begin
			if (hv_q[j] && (OW'(j) >= req_k)) begin
				scan_hit = 1'b1;
				scan_lvl = OW'(j);
			end
		end
	end

	always_comb begin
		head_d = head_q;
		hv_d   = hv_q;
		if (h0_we) begin
			head_d[h0_idx] = h0_link;
			hv_d[h0_idx]   = h0_v;
		end
		if (h1_we) begin
			head_d[h1_idx] = h1_link;
			hv_d[h1_idx]   = 1'b1;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		hk        = lvl_q;
		h0_we     = 1'b0;
		h0_idx    = lvl_q;
		h0_link   = rword.link;
		h0_v      = rword.nv;
		h1_we     = 1'b0;
		h1_idx    = km1;
		h1_link   = b_q;
		res_we    = 1'b0;
		res_code  = STAT_OK;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '{nv: 1'b0, link: '0, ord: '0, held: 1'b1};
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (op_q == OP_ALLOC) begin
					if (!req_ok) begin
						res_we   = 1'b1;
						res_code = STAT_TOO_LARGE;
						state_d  = ST_DONE;
					end else if (!scan_hit) begin
						res_we   = 1'b1;
						res_code = STAT_NO_MEM;
						state_d  = ST_DONE;
					end else begin
						state_d = ST_A_RD;
					end
				end else begin
					if (oor) begin
						res_we   = 1'b1;
						res_code = STAT_RANGE;
						state_d  = ST_DONE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = diff[IW-1:0];
						state_d   = ST_F_RD;
					end
				end
			end
			ST_A_RD: begin
				hk        = lvl_q;
				ram_re    = 1'b1;
				ram_raddr = hsel_link;
				state_d   = (lvl_q > req_k) ? ST_A_S1 : ST_A_FIN;
			end
			ST_A_S1: begin
				hk        = km1;
				h0_we     = 1'b1;
				h0_idx    = lvl_q;
				ram_we    = 1'b1;
				ram_waddr = b_q;
				ram_wdata = '{nv: hsel_v, link: hsel_link, ord: km1, held: 1'b0};
				h1_we     = 1'b1;
				h1_idx    = km1;
				h1_link   = b_q;
				state_d   = ST_A_S2;
			end
			ST_A_S2: begin
				ram_we    = 1'b1;
				ram_waddr = bud_a;
				ram_wdata = '{nv: 1'b1, link: b_q, ord: km1, held: 1'b0};
				h1_we     = 1'b1;
				h1_idx    = km1;
				h1_link   = bud_a;
				state_d   = ST_A_RD;
			end
			ST_A_FIN: begin
				h0_we     = 1'b1;
				h0_idx    = lvl_q;
				ram_we    = 1'b1;
				ram_waddr = b_q;
				ram_wdata = '{nv: 1'b0, link: rword.link, ord: rword.ord, held: 1'b1};
				res_we    = 1'b1;
				res_code  = STAT_OK;
				state_d   = ST_DONE;
			end
			ST_F_RD: begin
				if (!rword.held) begin
					res_we   = 1'b1;
					res_code = STAT_DBL_FREE;
					state_d  = ST_DONE;
				end else begin
					hk        = rword.ord;
					ram_we    = 1'b1;
					ram_waddr = p_q;
					ram_wdata = '{nv: hsel_v, link: hsel_link, ord: rword.ord, held: 1'b0};
					h1_we     = 1'b1;
					h1_idx    = rword.ord;
					h1_link   = p_q;
					state_d   = ST_M_CHK;
				end
			end
			ST_M_CHK: begin
				if (int'(k_q) >= MAX_ORDER) begin
					res_we   = 1'b1;
					res_code = STAT_OK;
					state_d  = ST_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = bud_m;
					state_d   = ST_M_BUD;
				end
			end
			ST_M_BUD: begin
				if ((rword.ord != k_q) || rword.held) begin
					res_we   = 1'b1;
					res_code = STAT_OK;
					state_d  = ST_DONE;
				end else begin
					state_d = ST_R_START;
				end
			end
			ST_R_START: begin
				hk = k_q;
				if (!hsel_v) begin
					state_d = ST_R_END;
				end else if (hsel_link == tgt_q) begin
					ram_re    = 1'b1;
					ram_raddr = tgt_q;
					state_d   = ST_R_POP;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = hsel_link;
					state_d   = ST_R_WALK;
				end
			end
			ST_R_WALK: begin
				if (walk_go) begin
					ram_re    = 1'b1;
					ram_raddr = rword.link;
				end else if (!found_q) begin
					state_d = ST_R_END;
				end else begin
					h1_we   = 1'b1;
					h1_idx  = k_q;
					h1_link = tgt_q;
					state_d = ST_R_WB;
				end
			end
			ST_R_WB: begin
				ram_we    = 1'b1;
				ram_waddr = before_q;
				ram_wdata = '{nv: 1'b0, link: bword_q.link, ord: bword_q.ord,
					held: bword_q.held};
				state_d   = ST_R_WT;
			end
			ST_R_WT: begin
				ram_we    = 1'b1;
				ram_waddr = t_q;
				ram_wdata = '{nv: 1'b1, link: first_q, ord: tword_q.ord, held: tword_q.held};
				state_d   = ST_R_RD;
			end
			ST_R_RD: begin
				ram_re    = 1'b1;
				ram_raddr = tgt_q;
				state_d   = ST_R_POP;
			end
			ST_R_POP: begin
				h0_we     = 1'b1;
				h0_idx    = k_q;
				ram_we    = 1'b1;
				ram_waddr = tgt_q;
				ram_wdata = '{nv: 1'b0, link: rword.link, ord: rword.ord, held: 1'b1};
				state_d   = ST_R_END;
			end
			ST_R_END: begin
				state_d = rm2_q ? ST_M_PUSH : ST_R_START;
			end
			ST_M_PUSH: begin
				hk        = kp1;
				ram_we    = 1'b1;
				ram_waddr = lo_q;
				ram_wdata = '{nv: hsel_v, link: hsel_link, ord: kp1, held: 1'b0};
				h1_we     = 1'b1;
				h1_idx    = kp1;
				h1_link   = lo_q;
				state_d   = ST_M_CHK;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			hv_q        <= '0;
			out_valid_q <= 1'b0;
			base_q      <= BASE_RST;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			hv_q <= hv_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= opcode;
			req_q <= order;
			pn_q  <= page_number;
		end
		head_q <= head_d;
		if (res_we) begin
			rs_status_q <= res_code;
			rs_page_q   <= (state_q == ST_A_FIN) ? base_q + PN_W'(b_q) : '0;
		end
		if (out_load) begin
			status_q <= rs_status_q;
			page_q   <= rs_page_q;
		end
		case (state_q)
			ST_DECODE: begin
				lvl_q <= scan_lvl;
				p_q   <= diff[IW-1:0];
			end
			ST_A_RD: begin
				b_q <= hsel_link;
			end
			ST_A_S2: begin
				lvl_q <= km1;
			end
			ST_F_RD: begin
				k_q <= rword.ord;
			end
			ST_M_CHK: begin
				b_q <= bud_m;
			end
			ST_M_BUD: begin
				tgt_q <= hi_c;
				lo_q  <= lo_c;
				rm2_q <= 1'b0;
			end
			ST_R_START: begin
				t_q     <= hsel_link;
				first_q <= hsel_link;
				steps_q <= '0;
				found_q <= 1'b0;
			end
			ST_R_WALK: begin
				if (walk_go) begin
					t_q     <= rword.link;
					steps_q <= steps_q + (IW + 1)'(1);
					if (rword.link == tgt_q) begin
						before_q <= t_q;
						bword_q  <= rword;
						found_q  <= 1'b1;
					end
				end else begin
					tword_q <= rword;
				end
			end
			ST_R_END: begin
				if (!rm2_q) begin
					tgt_q <= lo_q;
					rm2_q <= 1'b1;
				end
			end
			ST_M_PUSH: begin
				p_q <= lo_q;
				k_q <= kp1;
			end
			default: begin
			end
		endcase
	end

endmodule
